// File: src/rlr_pkg.sv
// rlr_pkg: shared types and constants of the running linear regression block
// word layouts, step codes of the fit sequence, controller/datapath command and status
// no dependencies
package rlr_pkg;

    localparam int MAX_POINTS  = 65536;
    localparam int SAMPLE_BITS = 16;
    localparam int MIN_FIT     = 3;

    localparam int CNT_W     = 17;
    localparam int SX_W      = 33;
    localparam int SQ_W      = 47;
    localparam int SXY_W     = 48;
    localparam int MUL_W     = 64;
    localparam int MUL_DIG_W = 16;
    localparam int MUL_CNT_W = 2;
    localparam int PROD_W    = 128;
    localparam int NUMA_W    = 96;
    localparam int DIV_W     = 192;
    localparam int QUO_W     = 65;
    localparam int K_W       = 7;
    localparam int RATIO_K   = 33;
    localparam int ERR_K     = 64;
    localparam int RATIO_FRAC = 17;
    localparam int STAT_FRAC  = 32;
    localparam int SQ_IN_W   = 68;
    localparam int ROOT_W    = 34;
    localparam int SQ_CNT_W  = 6;

    localparam logic [RATIO_K-1:0] Q_ONE = 33'h1_0000_0000;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] x_value;
        logic signed [SAMPLE_BITS-1:0] y_value;
        logic                          start_new;
    } rlr_in_t;

    typedef struct packed {
        logic signed [31:0] intercept;
        logic signed [31:0] slope;
        logic [16:0]        r_squared;
        logic [16:0]        correlation;
        logic [31:0]        std_error;
        logic               fit_valid;
        logic [CNT_W-1:0]   point_count;
        logic               count_full;
    } rlr_out_t;

    typedef enum logic [4:0] {
        STEP_NSXX,
        STEP_DX,
        STEP_NSYY,
        STEP_DY,
        STEP_NSXY,
        STEP_NXY,
        STEP_SYSXX,
        STEP_NUMA,
        STEP_N2,
        STEP_DD,
        STEP_NN2,
        STEP_DEN,
        STEP_DIV_SLOPE,
        STEP_DIV_ICPT,
        STEP_DIV_R2,
        STEP_DIV_ERR,
        STEP_SQ_CORR,
        STEP_SQ_ERR
    } step_t;

    typedef struct packed {
        logic  accept;
        logic  start;
        logic  commit;
        logic  load_out;
        step_t step;
    } rlr_cmd_t;

    typedef struct packed {
        logic unit_done;
        logic fit_ok;
    } rlr_stat_t;

endpackage

// File: src/rlr_div.sv
// rlr_div: restoring divider, one quotient bit per cycle, shifted divisor form
// gives k+1 quotient bits, the top one set when the quotient does not fit in k bits
// depends on rlr_pkg
module rlr_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rlr_pkg::DIV_W-1:0]     num,
    input  logic [rlr_pkg::PROD_W-1:0]    den,
    input  logic [rlr_pkg::K_W-1:0]       k,
    output logic [rlr_pkg::QUO_W-1:0]     quo,
    output logic                          done
);

    logic [rlr_pkg::DIV_W-1:0] rem_reg;
    logic [rlr_pkg::DIV_W-1:0] dsh_reg;
    logic [rlr_pkg::QUO_W-1:0] quo_reg;
    logic [rlr_pkg::K_W-1:0]   cnt_reg;
    logic                      busy_reg;
    logic                      done_reg;
    logic                      ge;

    assign ge   = rem_reg >= dsh_reg;
    assign quo  = quo_reg;
    assign done = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= k;
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            dsh_reg <= rlr_pkg::DIV_W'(den) << k;
            quo_reg <= '0;
        end else if (busy_reg) begin
            if (ge) begin
                rem_reg <= rem_reg - dsh_reg;
            end
            quo_reg <= {quo_reg[rlr_pkg::QUO_W-2:0], ge};
            dsh_reg <= dsh_reg >> 1;
        end
    end

endmodule

// File: src/rlr_sqrt.sv
// rlr_sqrt: digit-by-digit integer square root, one root bit per cycle
// floor square root of a 68-bit value
// depends on rlr_pkg
module rlr_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [rlr_pkg::SQ_IN_W-1:0]   val,
    output logic [rlr_pkg::ROOT_W-1:0]    root,
    output logic                          done
);

    logic [rlr_pkg::SQ_IN_W-1:0]  x_reg;
    logic [rlr_pkg::ROOT_W+2:0]   rem_reg;
    logic [rlr_pkg::ROOT_W-1:0]   root_reg;
    logic [rlr_pkg::SQ_CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic [rlr_pkg::ROOT_W+4:0]   rem_sh;
    logic [rlr_pkg::ROOT_W+4:0]   trial;
    logic                         ge;

    assign rem_sh = {rem_reg, x_reg[rlr_pkg::SQ_IN_W-1 -: 2]};
    assign trial  = {3'b000, root_reg, 2'b01};
    assign ge     = rem_sh >= trial;
    assign root   = root_reg;
    assign done   = done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= rlr_pkg::SQ_CNT_W'(rlr_pkg::ROOT_W - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg    <= val;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            x_reg    <= x_reg << 2;
            rem_reg  <= ge ? rlr_pkg::ROOT_W'(0) + (rlr_pkg::ROOT_W+3)'(rem_sh - trial)
                           : (rlr_pkg::ROOT_W+3)'(rem_sh);
            root_reg <= {root_reg[rlr_pkg::ROOT_W-2:0], ge};
        end
    end

endmodule

// File: src/rlr_ctrl.sv
// rlr_ctrl: sequencer of the running linear regression block
// walks the fit steps, handshakes both channels, drives commands into rlr_dp
// depends on rlr_pkg
module rlr_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 m_valid,
    input  logic                 m_ready,
    input  rlr_pkg::rlr_stat_t   stat,
    output rlr_pkg::rlr_cmd_t    cmd
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_WAIT  = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t         state_reg, state_next;
    rlr_pkg::step_t step_reg, step_next;
    logic           m_valid_reg, m_valid_next;
    logic           accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid & s_ready;
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        m_valid_next = m_valid_reg & ~m_ready;
        cmd.accept   = accept;
        cmd.start    = 1'b0;
        cmd.commit   = 1'b0;
        cmd.load_out = 1'b0;
        cmd.step     = step_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    step_next  = rlr_pkg::STEP_NSXX;
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (step_reg == rlr_pkg::STEP_NSYY && !stat.fit_ok) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.start  = 1'b1;
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (stat.unit_done) begin
                    cmd.commit = 1'b1;
                    if (step_reg == rlr_pkg::STEP_SQ_ERR) begin
                        state_next = ST_OUT;
                    end else begin
                        step_next  = rlr_pkg::step_t'(step_reg + 5'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= rlr_pkg::STEP_NSXX;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// File: src/rlr_dp.sv
// rlr_dp: datapath of the running linear regression block
// running sums, shared multiplier, divider and square root units, result register
// depends on rlr_pkg, rlr_div, rlr_sqrt
module rlr_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  rlr_pkg::rlr_cmd_t    cmd,
    output rlr_pkg::rlr_stat_t   stat,
    input  rlr_pkg::rlr_in_t     s_data,
    output rlr_pkg::rlr_out_t    m_data
);

    // running sums
    logic [rlr_pkg::CNT_W-1:0]        n_reg;
    logic signed [rlr_pkg::SX_W-1:0]  sx_reg, sy_reg;
    logic [rlr_pkg::SQ_W-1:0]         sxx_reg, syy_reg;
    logic signed [rlr_pkg::SXY_W-1:0] sxy_reg;
    logic                             full_reg;

    logic [rlr_pkg::CNT_W-1:0]        n_base;
    logic signed [rlr_pkg::SX_W-1:0]  sx_base, sy_base;
    logic [rlr_pkg::SQ_W-1:0]         sxx_base, syy_base;
    logic signed [rlr_pkg::SXY_W-1:0] sxy_base;
    logic                             full_now;
    logic signed [31:0]               xsq, ysq, xyp;

    // fit quantities
    logic [rlr_pkg::MUL_W-1:0]         dx_reg, dy_reg;
    logic signed [rlr_pkg::MUL_W-1:0]  nxy_reg;
    logic signed [rlr_pkg::NUMA_W-1:0] numa_reg;
    logic [rlr_pkg::PROD_W-1:0]        n2_reg, dd_reg, den_reg;
    logic signed [rlr_pkg::PROD_W-1:0] acc_reg;

    logic [rlr_pkg::SX_W-1:0]   sx_mag, sy_mag;
    logic [rlr_pkg::SXY_W-1:0]  sxy_mag;
    logic [rlr_pkg::MUL_W-1:0]  nxy_mag;
    logic [rlr_pkg::NUMA_W-1:0] numa_mag;
    logic [rlr_pkg::PROD_W-1:0] resid;

    // multiplier
    logic [rlr_pkg::MUL_W-1:0]             mul_a_reg, mul_b_reg;
    logic [rlr_pkg::PROD_W-1:0]            mul_acc_reg;
    logic [rlr_pkg::MUL_CNT_W-1:0]         mul_cnt_reg;
    logic                                  mul_busy_reg, mul_done_reg;
    logic [rlr_pkg::MUL_W+rlr_pkg::MUL_DIG_W-1:0] mul_pp;
    logic [rlr_pkg::MUL_W-1:0]             mul_a, mul_b;
    logic                                  mul_neg, mul_sub;
    logic signed [rlr_pkg::PROD_W-1:0]     prod_s, mul_res;

    // divider and square root
    logic [rlr_pkg::DIV_W-1:0]   div_num;
    logic [rlr_pkg::PROD_W-1:0]  div_den;
    logic [rlr_pkg::K_W-1:0]     div_k;
    logic [rlr_pkg::QUO_W-1:0]   div_quo;
    logic                        div_done;
    logic [rlr_pkg::SQ_IN_W-1:0] sq_in;
    logic [rlr_pkg::ROOT_W-1:0]  sq_root;
    logic                        sq_done;

    logic is_mul, is_div;

    logic [rlr_pkg::RATIO_K:0]   slope_q_reg, icpt_q_reg;
    logic [rlr_pkg::RATIO_K-1:0] r2_qv_reg, r2_qv;
    logic [rlr_pkg::QUO_W-1:0]   err_q_reg;
    logic [rlr_pkg::ROOT_W-1:0]  corr_root_reg, err_root_reg;

    rlr_pkg::rlr_out_t out_reg, out_next;
    logic [rlr_pkg::ROOT_W:0] corr_c, err_s;
    logic [rlr_pkg::RATIO_K:0] r2_round;
    logic fit_ok, dy_nz;

    function automatic logic [31:0] q16_sat(input logic [rlr_pkg::RATIO_K:0] q,
                                            input logic neg);
        logic [rlr_pkg::RATIO_K:0] v;
        logic [31:0]               r;
        v = ({1'b0, q[rlr_pkg::RATIO_K-1:0]} + 1'b1) >> 1;
        if (!neg) begin
            r = (q[rlr_pkg::RATIO_K] || v > 34'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : v[31:0];
        end else begin
            r = (q[rlr_pkg::RATIO_K] || v > 34'h0_8000_0000) ? 32'h8000_0000
                                                              : 32'd0 - v[31:0];
        end
        return r;
    endfunction

    // accumulate on accept
    assign n_base   = s_data.start_new ? '0 : n_reg;
    assign sx_base  = s_data.start_new ? '0 : sx_reg;
    assign sy_base  = s_data.start_new ? '0 : sy_reg;
    assign sxx_base = s_data.start_new ? '0 : sxx_reg;
    assign syy_base = s_data.start_new ? '0 : syy_reg;
    assign sxy_base = s_data.start_new ? '0 : sxy_reg;
    assign full_now = (n_base == rlr_pkg::CNT_W'(rlr_pkg::MAX_POINTS));
    assign xsq = s_data.x_value * s_data.x_value;
    assign ysq = s_data.y_value * s_data.y_value;
    assign xyp = s_data.x_value * s_data.y_value;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg    <= '0;
            sx_reg   <= '0;
            sy_reg   <= '0;
            sxx_reg  <= '0;
            syy_reg  <= '0;
            sxy_reg  <= '0;
            full_reg <= 1'b0;
        end else if (cmd.accept) begin
            full_reg <= full_now;
            if (full_now) begin
                n_reg   <= n_base;
                sx_reg  <= sx_base;
                sy_reg  <= sy_base;
                sxx_reg <= sxx_base;
                syy_reg <= syy_base;
                sxy_reg <= sxy_base;
            end else begin
                n_reg   <= n_base + 1'b1;
                sx_reg  <= sx_base + rlr_pkg::SX_W'(s_data.x_value);
                sy_reg  <= sy_base + rlr_pkg::SX_W'(s_data.y_value);
                sxx_reg <= sxx_base + rlr_pkg::SQ_W'($unsigned(xsq));
                syy_reg <= syy_base + rlr_pkg::SQ_W'($unsigned(ysq));
                sxy_reg <= sxy_base + rlr_pkg::SXY_W'(xyp);
            end
        end
    end

    // magnitudes
    assign sx_mag   = sx_reg[rlr_pkg::SX_W-1] ? rlr_pkg::SX_W'(-sx_reg) : sx_reg;
    assign sy_mag   = sy_reg[rlr_pkg::SX_W-1] ? rlr_pkg::SX_W'(-sy_reg) : sy_reg;
    assign sxy_mag  = sxy_reg[rlr_pkg::SXY_W-1] ? rlr_pkg::SXY_W'(-sxy_reg) : sxy_reg;
    assign nxy_mag  = nxy_reg[rlr_pkg::MUL_W-1] ? rlr_pkg::MUL_W'(-nxy_reg) : nxy_reg;
    assign numa_mag = numa_reg[rlr_pkg::NUMA_W-1] ? rlr_pkg::NUMA_W'(-numa_reg) : numa_reg;
    assign resid    = (dd_reg >= n2_reg) ? dd_reg - n2_reg : '0;

    assign fit_ok = (n_reg >= rlr_pkg::CNT_W'(rlr_pkg::MIN_FIT)) && (dx_reg != '0);
    assign dy_nz  = (dy_reg != '0);

    assign is_mul = (cmd.step <= rlr_pkg::STEP_DEN);
    assign is_div = (cmd.step >= rlr_pkg::STEP_DIV_SLOPE) && (cmd.step <= rlr_pkg::STEP_DIV_ERR);

    assign stat.fit_ok    = fit_ok;
    assign stat.unit_done = is_mul ? mul_done_reg : (is_div ? div_done : sq_done);

    // multiply operand selection
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_neg = 1'b0;
        mul_sub = 1'b0;
        unique case (cmd.step)
            rlr_pkg::STEP_NSXX: begin
                mul_a = rlr_pkg::MUL_W'(n_reg);
                mul_b = rlr_pkg::MUL_W'(sxx_reg);
            end
            rlr_pkg::STEP_DX: begin
                mul_a   = rlr_pkg::MUL_W'(sx_mag);
                mul_b   = rlr_pkg::MUL_W'(sx_mag);
                mul_sub = 1'b1;
            end
            rlr_pkg::STEP_NSYY: begin
                mul_a = rlr_pkg::MUL_W'(n_reg);
                mul_b = rlr_pkg::MUL_W'(syy_reg);
            end
            rlr_pkg::STEP_DY: begin
                mul_a   = rlr_pkg::MUL_W'(sy_mag);
                mul_b   = rlr_pkg::MUL_W'(sy_mag);
                mul_sub = 1'b1;
            end
            rlr_pkg::STEP_NSXY: begin
                mul_a   = rlr_pkg::MUL_W'(n_reg);
                mul_b   = rlr_pkg::MUL_W'(sxy_mag);
                mul_neg = sxy_reg[rlr_pkg::SXY_W-1];
            end
            rlr_pkg::STEP_NXY: begin
                mul_a   = rlr_pkg::MUL_W'(sx_mag);
                mul_b   = rlr_pkg::MUL_W'(sy_mag);
                mul_neg = sx_reg[rlr_pkg::SX_W-1] ^ sy_reg[rlr_pkg::SX_W-1];
                mul_sub = 1'b1;
            end
            rlr_pkg::STEP_SYSXX: begin
                mul_a   = rlr_pkg::MUL_W'(sy_mag);
                mul_b   = rlr_pkg::MUL_W'(sxx_reg);
                mul_neg = sy_reg[rlr_pkg::SX_W-1];
            end
            rlr_pkg::STEP_NUMA: begin
                mul_a   = rlr_pkg::MUL_W'(sx_mag);
                mul_b   = rlr_pkg::MUL_W'(sxy_mag);
                mul_neg = sx_reg[rlr_pkg::SX_W-1] ^ sxy_reg[rlr_pkg::SXY_W-1];
                mul_sub = 1'b1;
            end
            rlr_pkg::STEP_N2: begin
                mul_a = nxy_mag;
                mul_b = nxy_mag;
            end
            rlr_pkg::STEP_DD: begin
                mul_a = dx_reg;
                mul_b = dy_reg;
            end
            rlr_pkg::STEP_NN2: begin
                mul_a = rlr_pkg::MUL_W'(n_reg);
                mul_b = rlr_pkg::MUL_W'(n_reg - 2'd2);
            end
            rlr_pkg::STEP_DEN: begin
                mul_a = acc_reg[rlr_pkg::MUL_W-1:0];
                mul_b = dx_reg;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    // 64x64 multiply, one 16-bit digit of b per cycle
    assign mul_pp = mul_a_reg * mul_b_reg[{mul_cnt_reg, 4'b0000} +: rlr_pkg::MUL_DIG_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_busy_reg <= 1'b0;
            mul_done_reg <= 1'b0;
            mul_cnt_reg  <= '0;
        end else begin
            mul_done_reg <= 1'b0;
            if (cmd.start && is_mul) begin
                mul_busy_reg <= 1'b1;
                mul_cnt_reg  <= '0;
            end else if (mul_busy_reg) begin
                mul_cnt_reg <= mul_cnt_reg + 1'b1;
                if (mul_cnt_reg == '1) begin
                    mul_busy_reg <= 1'b0;
                    mul_done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start && is_mul) begin
            mul_a_reg   <= mul_a;
            mul_b_reg   <= mul_b;
            mul_acc_reg <= '0;
        end else if (mul_busy_reg) begin
            mul_acc_reg <= mul_acc_reg
                         + (rlr_pkg::PROD_W'(mul_pp) << {mul_cnt_reg, 4'b0000});
        end
    end

    assign prod_s  = mul_neg ? -$signed(mul_acc_reg) : $signed(mul_acc_reg);
    assign mul_res = mul_sub ? acc_reg - prod_s : prod_s;

    // divider operand selection
    always_comb begin
        div_num = '0;
        div_den = '0;
        div_k   = rlr_pkg::K_W'(rlr_pkg::RATIO_K);
        unique case (cmd.step)
            rlr_pkg::STEP_DIV_SLOPE: begin
                div_num = rlr_pkg::DIV_W'(nxy_mag) << rlr_pkg::RATIO_FRAC;
                div_den = rlr_pkg::PROD_W'(dx_reg);
            end
            rlr_pkg::STEP_DIV_ICPT: begin
                div_num = rlr_pkg::DIV_W'(numa_mag) << rlr_pkg::RATIO_FRAC;
                div_den = rlr_pkg::PROD_W'(dx_reg);
            end
            rlr_pkg::STEP_DIV_R2: begin
                div_num = rlr_pkg::DIV_W'(n2_reg) << rlr_pkg::STAT_FRAC;
                div_den = dd_reg;
            end
            rlr_pkg::STEP_DIV_ERR: begin
                div_num = rlr_pkg::DIV_W'(resid) << rlr_pkg::STAT_FRAC;
                div_den = den_reg;
                div_k   = rlr_pkg::K_W'(rlr_pkg::ERR_K);
            end
            default: begin
                div_num = '0;
            end
        endcase
    end

    assign sq_in = (cmd.step == rlr_pkg::STEP_SQ_CORR)
                 ? rlr_pkg::SQ_IN_W'(r2_qv_reg) << 2
                 : rlr_pkg::SQ_IN_W'(err_q_reg[rlr_pkg::ERR_K-1:0]) << 2;

    rlr_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start & is_div),
        .num     (div_num),
        .den     (div_den),
        .k       (div_k),
        .quo     (div_quo),
        .done    (div_done)
    );

    rlr_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start & ~is_mul & ~is_div),
        .val     (sq_in),
        .root    (sq_root),
        .done    (sq_done)
    );

    // r squared ratio clamped to one
    assign r2_qv = (div_quo[rlr_pkg::RATIO_K]
                    || div_quo[rlr_pkg::RATIO_K-1:0] > rlr_pkg::Q_ONE)
                 ? rlr_pkg::Q_ONE : div_quo[rlr_pkg::RATIO_K-1:0];

    // commit unit results
    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            unique case (cmd.step)
                rlr_pkg::STEP_NSXX, rlr_pkg::STEP_NSYY, rlr_pkg::STEP_NSXY,
                rlr_pkg::STEP_SYSXX, rlr_pkg::STEP_NN2: begin
                    acc_reg <= mul_res;
                end
                rlr_pkg::STEP_DX: begin
                    acc_reg <= mul_res;
                    dx_reg  <= mul_res[rlr_pkg::MUL_W-1:0];
                end
                rlr_pkg::STEP_DY: begin
                    acc_reg <= mul_res;
                    dy_reg  <= mul_res[rlr_pkg::MUL_W-1:0];
                end
                rlr_pkg::STEP_NXY: begin
                    acc_reg <= mul_res;
                    nxy_reg <= mul_res[rlr_pkg::MUL_W-1:0];
                end
                rlr_pkg::STEP_NUMA: begin
                    acc_reg  <= mul_res;
                    numa_reg <= mul_res[rlr_pkg::NUMA_W-1:0];
                end
                rlr_pkg::STEP_N2: begin
                    acc_reg <= mul_res;
                    n2_reg  <= mul_res;
                end
                rlr_pkg::STEP_DD: begin
                    acc_reg <= mul_res;
                    dd_reg  <= mul_res;
                end
                rlr_pkg::STEP_DEN: begin
                    acc_reg <= mul_res;
                    den_reg <= mul_res;
                end
                rlr_pkg::STEP_DIV_SLOPE: begin
                    slope_q_reg <= div_quo[rlr_pkg::RATIO_K:0];
                end
                rlr_pkg::STEP_DIV_ICPT: begin
                    icpt_q_reg <= div_quo[rlr_pkg::RATIO_K:0];
                end
                rlr_pkg::STEP_DIV_R2: begin
                    r2_qv_reg <= r2_qv;
                end
                rlr_pkg::STEP_DIV_ERR: begin
                    err_q_reg <= div_quo;
                end
                rlr_pkg::STEP_SQ_CORR: begin
                    corr_root_reg <= sq_root;
                end
                rlr_pkg::STEP_SQ_ERR: begin
                    err_root_reg <= sq_root;
                end
                default: begin
                    acc_reg <= acc_reg;
                end
            endcase
        end
    end

    // result word
    assign r2_round = ({1'b0, r2_qv_reg} + 34'h0_0000_8000) >> 16;
    assign corr_c   = ({1'b0, corr_root_reg} + 1'b1) >> 1;
    assign err_s    = ({1'b0, err_root_reg} + 1'b1) >> 1;

    always_comb begin
        out_next             = '0;
        out_next.point_count = n_reg;
        out_next.count_full  = full_reg;
        if (fit_ok) begin
            out_next.fit_valid = 1'b1;
            out_next.slope     = q16_sat(slope_q_reg, nxy_reg < 0);
            out_next.intercept = q16_sat(icpt_q_reg, numa_reg < 0);
            if (dy_nz) begin
                out_next.r_squared   = r2_round[16:0];
                out_next.correlation = (corr_c > 35'd65536) ? 17'd65536 : corr_c[16:0];
            end
            out_next.std_error = (err_q_reg[rlr_pkg::ERR_K]
                                  || err_s[rlr_pkg::ROOT_W:32] != '0)
                               ? 32'hFFFF_FFFF : err_s[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_reg <= out_next;
        end
    end

    assign m_data = out_reg;

endmodule

// File: src/running_linear_regression.sv
// running_linear_regression: running least-squares line fit, top level
// joins the sequencer rlr_ctrl and the datapath rlr_dp
// depends on rlr_pkg, rlr_ctrl, rlr_dp
//
// s_ channel: one word per point (x_value, y_value, start_new), valid/ready.
// start_new clears the running sums before the point is added.
// m_ channel: one result word per point: intercept and slope in Q16.16,
// r_squared and correlation in Q1.16, std_error in Q16.16, fit_valid,
// point_count and count_full, valid/ready.
// From accept to result a point needs twelve 64x64
// products on a multiplier that takes one 16-bit digit a cycle, four
// divisions of one quotient bit a cycle (34 bits for slope, intercept and
// r squared, 65 for the error term) and two square roots of 34 root bits.
// Without a fit (fewer than three points or zero x spread) the sequence
// stops after the x spread products and goes straight to the result.
// One point is in work at a time; the next is accepted as soon as the
// result is in the output register, even while the receiver stalls.
// A stalled result holds the block at its last step until taken.
// Reset clears the sums, the point count and both channels.
module running_linear_regression (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  rlr_pkg::rlr_in_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output rlr_pkg::rlr_out_t   m_data
);

    rlr_pkg::rlr_cmd_t  cmd;
    rlr_pkg::rlr_stat_t stat;

    rlr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    rlr_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_data  (m_data)
    );

endmodule

// File: dv/rlr_checker.sv
// rlr_checker: watches both channels of running_linear_regression, predicts each result
// word from the accepted point words and compares them field by field
// depends on rlr_pkg
`timescale 1ns / 100ps
module rlr_checker (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  rlr_pkg::rlr_in_t  s_data,
    input  logic              m_valid,
    input  logic              m_ready,
    input  rlr_pkg::rlr_out_t m_data,
    output int                errors,
    output int                pending,
    output int                fits_seen,
    output int                full_seen
);

    logic [63:0]       n_pts, sum_x, sum_y, sum_xx, sum_yy, sum_xy;
    rlr_pkg::rlr_out_t fit_queue[$];

    // rounded Q16.16 quotient, saturated to 32 bits
    function automatic logic [31:0] q16_quotient(input logic [127:0] num,
                                                 input logic [63:0] den);
        logic         neg;
        logic         big;
        logic [127:0] mag;
        logic [191:0] quo;
        logic [63:0]  lo, v;
        neg = num[127];
        mag = neg ? -num : num;
        quo = {47'b0, mag, 17'b0} / {128'b0, den};
        big = quo[127:64] != 0;
        lo  = quo[63:0];
        v   = (lo >> 1) + {63'b0, lo[0]};
        if (v < (lo >> 1))
            big = 1'b1;
        if (!neg) begin
            if (big || v > 64'h7FFF_FFFF)
                v = 64'h7FFF_FFFF;
            return v[31:0];
        end
        if (big || v > 64'h8000_0000)
            v = 64'h8000_0000;
        return 32'(64'd0 - v);
    endfunction

    function automatic logic [127:0] frac32_quotient(input logic [127:0] num,
                                                     input logic [127:0] den);
        logic [191:0] quo;
        quo = {32'b0, num, 32'b0} / {64'b0, den};
        return quo[127:0];
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [127:0] val);
        logic [63:0] root, cand;
        root = 0;
        for (int b = 63; b >= 0; b--) begin
            cand = root | (64'd1 << b);
            if ({64'b0, cand} * {64'b0, cand} <= val)
                root = cand;
        end
        return root;
    endfunction

    function automatic rlr_pkg::rlr_out_t fit_point(input rlr_pkg::rlr_in_t w);
        rlr_pkg::rlr_out_t r;
        logic [63:0]       xv, yv, dx, dy, nxy, nmag, qv, c, s, nn, root4;
        logic [127:0]      icpt_num, n2, dd, q, resid, den, e, e4;
        r  = '0;
        xv = {{48{w.x_value[15]}}, w.x_value};
        yv = {{48{w.y_value[15]}}, w.y_value};
        if (w.start_new) begin
            n_pts = 0; sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
        end
        if (n_pts >= 64'(rlr_pkg::MAX_POINTS)) begin
            r.count_full = 1'b1;
        end else begin
            n_pts  = n_pts + 1;
            sum_x  = sum_x + xv;
            sum_y  = sum_y + yv;
            sum_xx = sum_xx + xv * xv;
            sum_yy = sum_yy + yv * yv;
            sum_xy = sum_xy + xv * yv;
        end
        r.point_count = n_pts[rlr_pkg::CNT_W-1:0];
        dx = n_pts * sum_xx - sum_x * sum_x;
        if (n_pts < 3 || dx == 0)
            return r;
        dy  = n_pts * sum_yy - sum_y * sum_y;
        nxy = n_pts * sum_xy - sum_x * sum_y;
        r.fit_valid = 1'b1;
        r.slope = q16_quotient({{64{nxy[63]}}, nxy}, dx);
        icpt_num = $signed({{64{sum_y[63]}}, sum_y}) * $signed({64'b0, sum_xx})
                 - $signed({{64{sum_x[63]}}, sum_x}) * $signed({{64{sum_xy[63]}}, sum_xy});
        r.intercept = q16_quotient(icpt_num, dx);
        nmag = nxy[63] ? -nxy : nxy;
        n2   = {64'b0, nmag} * {64'b0, nmag};
        dd   = {64'b0, dx} * {64'b0, dy};
        if (dy != 0) begin
            q  = frac32_quotient(n2, dd);
            qv = (q[127:64] != 0 || q[63:0] > 64'h1_0000_0000) ? 64'h1_0000_0000 : q[63:0];
            c  = (floor_sqrt({64'b0, qv << 2}) + 1) >> 1;
            r.r_squared   = 17'((qv + 64'h8000) >> 16);
            r.correlation = c > 64'd65536 ? 17'd65536 : c[16:0];
        end
        resid = dd >= n2 ? dd - n2 : 128'd0;
        nn    = n_pts * (n_pts - 2);
        den   = {64'b0, nn} * {64'b0, dx};
        if (den == 0)
            return r;
        e  = frac32_quotient(resid, den);
        e4 = e << 2;
        if (e[127:126] != 0) begin
            r.std_error = 32'hFFFF_FFFF;
        end else begin
            root4 = floor_sqrt(e4);
            s = (root4 >> 1) + (root4 & 64'd1);
            r.std_error = s > 64'hFFFF_FFFF ? 32'hFFFF_FFFF : s[31:0];
        end
        return r;
    endfunction

    assign pending = fit_queue.size();

    always @(posedge aclk) begin
        rlr_pkg::rlr_out_t want;
        if (!aresetn) begin
            n_pts = 0; sum_x = 0; sum_y = 0; sum_xx = 0; sum_yy = 0; sum_xy = 0;
            fit_queue.delete();
            errors = 0;
            fits_seen <= 0;
            full_seen <= 0;
        end else begin
            if (s_valid && s_ready)
                fit_queue.push_back(fit_point(s_data));
            if (m_valid && m_ready) begin
                if (fit_queue.size() == 0) begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected result word %h", m_data);
                end else begin
                    want = fit_queue.pop_front();
                    fits_seen <= fits_seen + want.fit_valid;
                    full_seen <= full_seen + want.count_full;
                    if (m_data.intercept !== want.intercept || m_data.slope !== want.slope
                        || m_data.r_squared !== want.r_squared
                        || m_data.correlation !== want.correlation
                        || m_data.std_error !== want.std_error
                        || m_data.fit_valid !== want.fit_valid
                        || m_data.point_count !== want.point_count
                        || m_data.count_full !== want.count_full) begin
                        errors = errors + 1;
                        if (errors <= 10) begin
                            $display("exp: a=%0d b=%0d r2=%0d r=%0d se=%0d v=%0b n=%0d f=%0b",
                                     want.intercept, want.slope, want.r_squared,
                                     want.correlation, want.std_error, want.fit_valid,
                                     want.point_count, want.count_full);
                            $display("act: a=%0d b=%0d r2=%0d r=%0d se=%0d v=%0b n=%0d f=%0b",
                                     m_data.intercept, m_data.slope, m_data.r_squared,
                                     m_data.correlation, m_data.std_error, m_data.fit_valid,
                                     m_data.point_count, m_data.count_full);
                        end
                    end
                end
            end
        end
    end
endmodule

// File: dv/tb_running_linear_regression.sv
// tb_running_linear_regression: drives point words into running_linear_regression and
// gives the verdict; prediction and comparison sit in rlr_checker
// depends on rlr_pkg, rlr_checker, running_linear_regression
`timescale 1ns / 100ps
module tb_running_linear_regression;

    localparam int LIMIT = 8_000_000;

    logic              aclk = 0;
    logic              aresetn = 0;
    logic              s_valid = 0;
    logic              s_ready;
    rlr_pkg::rlr_in_t  s_data = '0;
    logic              m_valid;
    logic              m_ready = 0;
    rlr_pkg::rlr_out_t m_data;
    logic              quiet = 0;
    int                errors, pending, fits_seen, full_seen;
    int                cycles = 0;
    int                points = 0;

    always #1 aclk = ~aclk;

    running_linear_regression dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    rlr_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .errors(errors), .pending(pending), .fits_seen(fits_seen), .full_seen(full_seen)
    );

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= quiet || $urandom_range(99) >= 6;
    end

    task automatic send_point(input int xv, input int yv, input bit clear);
        s_valid <= 1'b1;
        s_data  <= '{x_value: 16'(xv), y_value: 16'(yv), start_new: clear};
        do @(posedge aclk); while (!(s_valid && s_ready));
        points++;
        if (!quiet && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge aclk);
        end
    endtask

    initial begin
        int mode, slope_k, offset, xv, wait_cnt;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // extremes
        send_point(0, 0, 0);
        send_point(32767, 32767, 0);
        send_point(-32768, -32768, 0);
        send_point(-32768, 32767, 0);
        send_point(32767, -32768, 0);
        // constant y
        send_point(1, 5, 1);
        send_point(2, 5, 0);
        send_point(3, 5, 0);
        send_point(-4, 5, 0);
        // exact line
        send_point(-100, -307, 1);
        send_point(0, -7, 0);
        send_point(50, 143, 0);
        send_point(1000, 2993, 0);
        // no x spread
        send_point(7, 1, 1);
        send_point(7, -2, 0);
        send_point(7, 3, 0);
        // only two points before a clear
        send_point(-32768, 100, 1);
        send_point(32767, -100, 0);

        mode = 0; slope_k = 0; offset = 0;
        for (int i = 0; i < 1600; i++) begin
            bit clear;
            quiet = i >= 600 && i < 900;
            clear = i == 0 || $urandom_range(39) == 0;
            if (clear) begin
                mode    = $urandom_range(3);
                slope_k = $urandom_range(20) - 10;
                offset  = $urandom_range(2000) - 1000;
            end
            case (mode)
                0: send_point($signed(16'($urandom)), $signed(16'($urandom)), clear);
                1: send_point($urandom_range(16) - 8, $urandom_range(16) - 8, clear);
                2: begin
                    xv = $urandom_range(4000) - 2000;
                    send_point(xv, slope_k * xv + offset + $urandom_range(6) - 3, clear);
                end
                default: begin
                    xv = $signed(16'($urandom));
                    send_point(xv, xv[0] ? -32768 : 32767, clear);
                end
            endcase
        end
        s_valid <= 1'b0;
        quiet = 0;

        while (pending != 0) @(posedge aclk);
        wait_cnt = 0;
        while (wait_cnt < 500) begin
            @(posedge aclk);
            wait_cnt++;
        end
        $display("sent %0d points over %0d cycles", points, cycles);
        $display("results with a fit: %0d, points refused by a full store: %0d",
                 fits_seen, full_seen);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
